>>> rtl/pne_pkg.sv
package pne_pkg;

    localparam int RADIUS = 4;
    localparam int MODES  = 2;
    localparam int SPAN   = 2 * RADIUS + 1;
    localparam int NCOEF  = SPAN * SPAN;
    localparam int CIW    = $clog2(NCOEF);
    localparam int SPW    = $clog2(SPAN + 1);
    localparam int WINW   = $clog2(SPAN);

    localparam logic CMD_COEF   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic REG_INV_GAIN_RE = 1'b0;
    localparam logic REG_INV_GAIN_IM = 1'b1;

    typedef logic signed [15:0] t_smp;
    typedef logic signed [17:0] t_cf;

    typedef struct packed {
        t_smp x_re;
        t_smp x_im;
        t_smp y_re;
        t_smp y_im;
    } t_pair;

    typedef struct packed {
        logic         shift;
        logic         term;
        logic [3:0]   dm;
        logic [3:0]   dn;
        logic         mode;
        logic         fin;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic fin_done;
    } t_sts;

    function automatic logic signed [63:0] rshift(input logic signed [63:0] x,
                                                   input int s);
        logic signed [63:0] t;
        t = x + (64'sd1 <<< (s - 1));
        return t >>> s;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] x,
                                                  output logic c);
        c = 1'b0;
        if (x > 64'sd32767) begin
            c = 1'b1;
            return 16'sh7fff;
        end
        if (x < -64'sd32768) begin
            c = 1'b1;
            return 16'sh8000;
        end
        return x[15:0];
    endfunction

endpackage

>>> rtl/pne_ram.sv
module pne_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 81
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/pne_ctrl.sv
module pne_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_out_busy,
    input  pne_pkg::t_sts i_sts,
    output pne_pkg::t_cmd o_cmd,
    output logic          o_ready
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RUN  = 4'b0010,
        S_FIN  = 4'b0100,
        S_WAIT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [3:0] r_dm, n_dm, r_dn, n_dn;
    logic       r_mode, n_mode;
    logic [3:0] lim;
    logic [3:0] dmabs;

    assign dmabs = (r_dm >= 4'(pne_pkg::RADIUS)) ? r_dm - 4'(pne_pkg::RADIUS)
                                                 : 4'(pne_pkg::RADIUS) - r_dm;
    assign lim = 4'(pne_pkg::RADIUS) - dmabs;

    always_comb begin
        n_state = r_state;
        n_dm    = r_dm;
        n_dn    = r_dn;
        n_mode  = r_mode;
        o_cmd   = '0;
        o_cmd.dm   = r_dm;
        o_cmd.dn   = r_dn;
        o_cmd.mode = r_mode;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    o_cmd.shift = 1'b1;
                    n_state = S_RUN;
                    n_mode  = 1'b0;
                    n_dm    = 4'd0;
                    n_dn    = 4'(pne_pkg::RADIUS);
                end
            end
            S_RUN: begin
                if (!i_sts.full) begin
                    n_state = S_FIN;
                    n_mode  = 1'b0;
                end else begin
                    o_cmd.term = 1'b1;
                    if (r_dn == 4'(pne_pkg::RADIUS) + lim) begin
                        if (r_dm == 4'(2 * pne_pkg::RADIUS)) begin
                            n_dm = 4'd0;
                            n_dn = 4'(pne_pkg::RADIUS);
                            if (r_mode == 1'(pne_pkg::MODES - 1)) begin
                                n_state = S_FIN;
                                n_mode  = 1'b0;
                            end else begin
                                n_mode = r_mode + 1'b1;
                            end
                        end else begin
                            n_dm = r_dm + 4'd1;
                            n_dn = 4'(pne_pkg::RADIUS) -
                                   ((r_dm + 4'd1 >= 4'(pne_pkg::RADIUS))
                                    ? 4'(pne_pkg::RADIUS) - (r_dm + 4'd1 - 4'(pne_pkg::RADIUS))
                                    : r_dm + 4'd1);
                        end
                    end else begin
                        n_dn = r_dn + 4'd1;
                    end
                end
            end
            S_FIN: begin
                if (!i_out_busy) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_sts.fin_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dm    <= '0;
            r_dn    <= '0;
            r_mode  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dm    <= n_dm;
            r_dn    <= n_dn;
            r_mode  <= n_mode;
        end
    end
endmodule

>>> rtl/pne_dp.sv
module pne_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  pne_pkg::t_cmd            i_cmd,
    input  pne_pkg::t_pair           i_tx,
    input  pne_pkg::t_pair           i_rx,
    input  logic                     i_coef_we,
    input  logic [pne_pkg::CIW-1:0]  i_coef_addr,
    input  pne_pkg::t_cf             i_coef_re,
    input  pne_pkg::t_cf             i_coef_im,
    input  pne_pkg::t_cf             i_g_re,
    input  pne_pkg::t_cf             i_g_im,
    input  logic                     i_out_stall,
    output pne_pkg::t_sts            o_sts,
    output logic                     o_busy,
    output logic                     o_valid,
    output pne_pkg::t_pair           o_eq,
    output logic                     o_full,
    output logic                     o_clip
);
    pne_pkg::t_pair r_tx [pne_pkg::SPAN];
    pne_pkg::t_pair r_rx [pne_pkg::RADIUS + 1];
    logic [pne_pkg::SPW-1:0] r_fill;
    logic [35:0] rdata;
    logic [pne_pkg::CIW-1:0] raddr;

    pne_ram #(.WIDTH(36), .DEPTH(pne_pkg::NCOEF)) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_coef_we),
        .i_waddr(i_coef_addr),
        .i_wdata({i_coef_re, i_coef_im}),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign raddr = pne_pkg::CIW'(i_cmd.dm * pne_pkg::SPAN + i_cmd.dn);

    // stage 1: inner polarization sum and center tap, read coefficient
    logic [pne_pkg::WINW:0] ia, ib;
    logic signed [4:0] sm, sn;
    logic signed [35:0] s_re, s_im;
    pne_pkg::t_pair pa, pb, pc;
    always_comb begin
        sm = 5'(signed'({1'b0, i_cmd.dm})) - 5'(pne_pkg::RADIUS);
        sn = 5'(signed'({1'b0, i_cmd.dn})) - 5'(pne_pkg::RADIUS);
        ia = (pne_pkg::WINW+1)'(pne_pkg::RADIUS + sn);
        ib = (pne_pkg::WINW+1)'(pne_pkg::RADIUS + sm + sn);
        pa = r_tx[ia[pne_pkg::WINW-1:0]];
        pb = r_tx[ib[pne_pkg::WINW-1:0]];
        pc = r_tx[i_cmd.dm[pne_pkg::WINW-1:0]];
        s_re = 36'(pa.x_re * pb.x_re) + 36'(pa.x_im * pb.x_im);
        s_im = 36'(pa.x_im * pb.x_re) - 36'(pa.x_re * pb.x_im);
        if (pne_pkg::MODES > 1) begin
            s_re = s_re + 36'(pa.y_re * pb.y_re) + 36'(pa.y_im * pb.y_im);
            s_im = s_im + 36'(pa.y_im * pb.y_re) - 36'(pa.y_re * pb.y_im);
        end
    end

    logic r_v1, r_v2, r_v3;
    logic r_mode_d1, r_mode_d2, r_mode_d3;
    logic signed [33:0] r_s_re, r_s_im;
    pne_pkg::t_smp r_c_re, r_c_im;
    logic signed [49:0] r_t_re, r_t_im;
    logic signed [63:0] t2_re, t2_im, w_re, w_im;
    logic signed [37:0] r_tr, r_ti;
    logic [35:0] r_cf1, r_cf2;
    logic signed [63:0] r_acc_re, r_acc_im;

    assign t2_re = pne_pkg::rshift(64'(r_t_re), 12);
    assign t2_im = pne_pkg::rshift(64'(r_t_im), 12);
    assign w_re = pne_pkg::rshift(
        64'($signed(r_cf2[35:18]) * r_tr) - 64'($signed(r_cf2[17:0]) * r_ti), 14);
    assign w_im = pne_pkg::rshift(
        64'($signed(r_cf2[35:18]) * r_ti) + 64'($signed(r_cf2[17:0]) * r_tr), 14);

    // final stage
    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_DIFF = 4'b0010,
        F_MUL  = 4'b0100,
        F_OUT  = 4'b1000
    } t_fst;
    t_fst r_f;
    logic r_fm;
    logic signed [63:0] r_acc_x_re, r_acc_x_im;
    logic signed [35:0] r_d_re, r_d_im;
    logic signed [63:0] r_y_re, r_y_im;
    pne_pkg::t_smp ya, yb;
    logic ca, cb;
    pne_pkg::t_pair r_eq;
    logic r_clip, r_valid, r_full;
    pne_pkg::t_pair rxk;
    logic signed [63:0] acc_sel_re, acc_sel_im;

    assign rxk = r_rx[pne_pkg::RADIUS];
    always_comb begin
        ya = pne_pkg::sat16(pne_pkg::rshift(r_y_re, 14), ca);
        yb = pne_pkg::sat16(pne_pkg::rshift(r_y_im, 14), cb);
        acc_sel_re = r_fm ? r_acc_re : r_acc_x_re;
        acc_sel_im = r_fm ? r_acc_im : r_acc_x_im;
    end

    always_ff @(posedge i_clk) begin
        r_mode_d1 <= i_cmd.mode;
        r_mode_d2 <= r_mode_d1;
        r_mode_d3 <= r_mode_d2;
    end

    always_ff @(posedge i_clk) begin
        r_s_re <= s_re[33:0];
        r_s_im <= s_im[33:0];
        r_c_re <= i_cmd.mode ? pc.y_re : pc.x_re;
        r_c_im <= i_cmd.mode ? pc.y_im : pc.x_im;
        r_t_re <= 50'(r_c_re * r_s_re) - 50'(r_c_im * r_s_im);
        r_t_im <= 50'(r_c_re * r_s_im) + 50'(r_c_im * r_s_re);
        r_tr <= t2_re[37:0];
        r_ti <= t2_im[37:0];
        r_cf1 <= rdata;
        r_cf2 <= r_cf1;
        if (!i_rst_n) begin
            for (int i = 0; i < pne_pkg::SPAN; i++) r_tx[i] <= '0;
            for (int i = 0; i <= pne_pkg::RADIUS; i++) r_rx[i] <= '0;
        end else if (i_cmd.shift) begin
            for (int i = 0; i < pne_pkg::SPAN - 1; i++) r_tx[i] <= r_tx[i + 1];
            r_tx[pne_pkg::SPAN - 1] <= i_tx;
            for (int i = 1; i <= pne_pkg::RADIUS; i++) r_rx[i] <= r_rx[i - 1];
            r_rx[0] <= i_rx;
        end
        if (i_cmd.shift) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
            r_acc_x_re <= '0;
            r_acc_x_im <= '0;
        end else if (r_v3) begin
            if (r_mode_d3) begin
                r_acc_re <= r_acc_re + w_re;
                r_acc_im <= r_acc_im + w_im;
            end else begin
                r_acc_x_re <= r_acc_x_re + w_re;
                r_acc_x_im <= r_acc_x_im + w_im;
            end
        end
        case (r_f)
            F_DIFF: begin
                r_d_re <= 36'(64'(r_fm ? rxk.y_re : rxk.x_re) - pne_pkg::rshift(acc_sel_re, 12));
                r_d_im <= 36'(64'(r_fm ? rxk.y_im : rxk.x_im) - pne_pkg::rshift(acc_sel_im, 12));
            end
            F_MUL: begin
                r_y_re <= 64'(i_g_re * r_d_re) - 64'(i_g_im * r_d_im);
                r_y_im <= 64'(i_g_re * r_d_im) + 64'(i_g_im * r_d_re);
            end
            F_OUT: begin
                if (!r_fm) begin
                    r_eq.x_re <= ya;
                    r_eq.x_im <= yb;
                    r_clip <= ca | cb;
                end else begin
                    r_eq.y_re <= ya;
                    r_eq.y_im <= yb;
                    r_clip <= r_clip | ca | cb;
                end
            end
            default: ;
        endcase
        if (i_cmd.fin) begin
            r_full <= (r_fill == pne_pkg::SPW'(pne_pkg::SPAN));
            r_eq <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_fill <= '0;
            r_f <= F_IDLE;
            r_fm <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_v1 <= i_cmd.term;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_cmd.shift && r_fill != pne_pkg::SPW'(pne_pkg::SPAN)) begin
                r_fill <= r_fill + 1'b1;
            end
            if (r_valid && !i_out_stall) begin
                r_valid <= 1'b0;
            end
            case (r_f)
                F_IDLE: begin
                    if (i_cmd.fin) begin
                        r_f <= F_DIFF;
                        r_fm <= 1'b0;
                    end
                end
                F_DIFF: r_f <= F_MUL;
                F_MUL:  r_f <= F_OUT;
                F_OUT: begin
                    if (!r_fm && pne_pkg::MODES > 1) begin
                        r_fm <= 1'b1;
                        r_f <= F_DIFF;
                    end else begin
                        r_f <= F_IDLE;
                        r_valid <= 1'b1;
                    end
                end
                default: r_f <= F_IDLE;
            endcase
        end
    end

    logic fin_done;
    assign fin_done = (r_f == F_OUT) && (r_fm || pne_pkg::MODES == 1);

    assign o_sts.full     = (r_fill == pne_pkg::SPW'(pne_pkg::SPAN));
    assign o_sts.fin_done = fin_done;
    assign o_busy  = r_valid || r_v1 || r_v2 || r_v3;
    assign o_valid = r_valid;
    assign o_eq    = r_eq;
    assign o_full  = r_full;
    assign o_clip  = r_clip;
endmodule

>>> rtl/perturbation_nonlinear_equalizer.sv
// channel  | handshake           | payload
// input    | i_valid / o_stall   | command, coefficient, tx and rx samples
// output   | o_valid / i_stall   | equalized samples, full_window, clipped
// config   | i_cfg_valid/o_cfg_ready | index, data
// With a full window a sample runs 2*41 terms (one complex triplet per cycle and
// polarization), then drains the 3-stage multiplier chain and runs difference, gain
// and saturation for each polarization; before the window fills, no terms are run.
// A sample is not accepted while the previous one is still in progress.
// Reset is synchronous; the delay lines and fill count clear, coefficients do not.
// The next request waits while a previous result is still held.
module perturbation_nonlinear_equalizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [6:0]  i_coef_index,
    input  logic signed [17:0] i_coef_re,
    input  logic signed [17:0] i_coef_im,
    input  logic signed [15:0] i_tx_x_re,
    input  logic signed [15:0] i_tx_x_im,
    input  logic signed [15:0] i_tx_y_re,
    input  logic signed [15:0] i_tx_y_im,
    input  logic signed [15:0] i_rx_x_re,
    input  logic signed [15:0] i_rx_x_im,
    input  logic signed [15:0] i_rx_y_re,
    input  logic signed [15:0] i_rx_y_im,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [15:0] o_eq_x_re,
    output logic signed [15:0] o_eq_x_im,
    output logic signed [15:0] o_eq_y_re,
    output logic signed [15:0] o_eq_y_im,
    output logic        o_full_window,
    output logic        o_clipped,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [17:0] i_cfg_data
);
    pne_pkg::t_cmd  cmd;
    pne_pkg::t_sts  sts;
    pne_pkg::t_pair tx, rx, eq;
    logic ready, busy, acc, start, cwe;
    pne_pkg::t_cf r_g_re, r_g_im;

    assign acc   = i_valid && !o_stall;
    assign start = acc && (i_command == pne_pkg::CMD_SAMPLE);
    assign cwe   = acc && (i_command == pne_pkg::CMD_COEF) &&
                   (i_coef_index < 7'(pne_pkg::NCOEF));
    assign o_stall = !ready || busy;
    assign o_cfg_ready = 1'b1;
    assign tx = '{i_tx_x_re, i_tx_x_im,
                  (pne_pkg::MODES > 1) ? i_tx_y_re : 16'sd0,
                  (pne_pkg::MODES > 1) ? i_tx_y_im : 16'sd0};
    assign rx = '{i_rx_x_re, i_rx_x_im,
                  (pne_pkg::MODES > 1) ? i_rx_y_re : 16'sd0,
                  (pne_pkg::MODES > 1) ? i_rx_y_im : 16'sd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_re <= 18'sd16384;
            r_g_im <= 18'sd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pne_pkg::REG_INV_GAIN_RE: r_g_re <= i_cfg_data;
                pne_pkg::REG_INV_GAIN_IM: r_g_im <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pne_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_out_busy(busy),
        .i_sts     (sts),
        .o_cmd     (cmd),
        .o_ready   (ready)
    );

    pne_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_tx       (tx),
        .i_rx       (rx),
        .i_coef_we  (cwe),
        .i_coef_addr(i_coef_index[pne_pkg::CIW-1:0]),
        .i_coef_re  (i_coef_re),
        .i_coef_im  (i_coef_im),
        .i_g_re     (r_g_re),
        .i_g_im     (r_g_im),
        .i_out_stall(i_stall),
        .o_sts      (sts),
        .o_busy     (busy),
        .o_valid    (o_valid),
        .o_eq       (eq),
        .o_full     (o_full_window),
        .o_clip     (o_clipped)
    );

    assign o_eq_x_re = eq.x_re;
    assign o_eq_x_im = eq.x_im;
    assign o_eq_y_re = eq.y_re;
    assign o_eq_y_im = eq.y_im;

    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("accept with result pending");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> o_stall) else $error("no stall after sample start");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid) else $error("result dropped");
endmodule
